// File: hw/rtl/sicpc_pkg.sv
// package with command codes, result type and priority encoder for the interrupt controller
`default_nettype none

package sicpc_pkg;

    localparam int unsigned CMD_W   = 3;
    localparam int unsigned VALUE_W = 16;
    localparam int unsigned BITS_W  = 15;
    localparam int unsigned LEVEL_W = 3;

    localparam int unsigned SETCLR_POS = 15;
    localparam int unsigned MASTER_POS = 14;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE_ENABLE  = 3'd0,
        CMD_WRITE_REQUEST = 3'd1,
        CMD_READ_ENABLE   = 3'd2,
        CMD_READ_REQUEST  = 3'd3,
        CMD_RAISE         = 3'd4,
        CMD_CLEAR         = 3'd5,
        CMD_QUERY         = 3'd6
    } cmd_t;

    typedef struct packed {
        logic [BITS_W-1:0]  read_data;
        logic               mask_pending;
        logic [LEVEL_W-1:0] priority_level;
        logic               level_changed;
    } result_t;

    function automatic logic [BITS_W-1:0] set_or_clear(
        input logic [BITS_W-1:0]  cur,
        input logic [VALUE_W-1:0] value
    );
        logic [BITS_W-1:0] m;
        m = value[BITS_W-1:0];
        if (value[SETCLR_POS]) begin
            return cur | m;
        end
        return cur & ~m;
    endfunction

    function automatic logic [LEVEL_W-1:0] encode_level(
        input logic [BITS_W-1:0] en,
        input logic [BITS_W-1:0] rq
    );
        logic [BITS_W-1:0] p;
        p = en & rq;
        priority if (!en[MASTER_POS]) begin
            return LEVEL_W'(0);
        end else if (p[13]) begin
            return LEVEL_W'(6);
        end else if (|p[12:11]) begin
            return LEVEL_W'(5);
        end else if (|p[10:7]) begin
            return LEVEL_W'(4);
        end else if (|p[6:4]) begin
            return LEVEL_W'(3);
        end else if (p[3]) begin
            return LEVEL_W'(2);
        end else if (|p[2:0]) begin
            return LEVEL_W'(1);
        end else begin
            return LEVEL_W'(0);
        end
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sicpc_in_reg.sv
// input register stage holding one accepted command
`default_nettype none

module sicpc_in_reg (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [sicpc_pkg::CMD_W-1:0]   in_command,
    input  wire logic [sicpc_pkg::VALUE_W-1:0] in_value,
    input  wire logic                          advance,
    output logic                               held_valid,
    output logic [sicpc_pkg::CMD_W-1:0]        held_command,
    output logic [sicpc_pkg::VALUE_W-1:0]      held_value
);
    import sicpc_pkg::*;

    logic                valid_reg;
    logic [CMD_W-1:0]    command_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic                load;

    assign in_ready = !valid_reg || advance;
    assign load     = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= load || (valid_reg && !advance);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            command_reg <= in_command;
            value_reg   <= in_value;
        end
    end

    assign held_valid   = valid_reg;
    assign held_command = command_reg;
    assign held_value   = value_reg;

endmodule

`default_nettype wire

// File: hw/rtl/sicpc_core.sv
// enable, request and level registers with command execution and priority encode
`default_nettype none

module sicpc_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          exec,
    input  wire logic [sicpc_pkg::CMD_W-1:0]   command,
    input  wire logic [sicpc_pkg::VALUE_W-1:0] value,
    output sicpc_pkg::result_t                 result
);
    import sicpc_pkg::*;

    logic [BITS_W-1:0]  enable_reg,  enable_next;
    logic [BITS_W-1:0]  request_reg, request_next;
    logic [LEVEL_W-1:0] level_reg,   level_next;
    logic [BITS_W-1:0]  mask;
    logic [BITS_W-1:0]  rd;
    logic               pend;

    assign mask = value[BITS_W-1:0];

    always_comb begin
        enable_next  = enable_reg;
        request_next = request_reg;
        rd           = '0;
        pend         = 1'b0;
        case (cmd_t'(command))
            CMD_WRITE_ENABLE:  enable_next  = set_or_clear(enable_reg, value);
            CMD_WRITE_REQUEST: request_next = set_or_clear(request_reg, value);
            CMD_READ_ENABLE:   rd           = enable_reg;
            CMD_READ_REQUEST:  rd           = request_reg;
            CMD_RAISE:         request_next = request_reg | mask;
            CMD_CLEAR:         request_next = request_reg & ~mask;
            CMD_QUERY:         pend         = |(request_reg & mask);
            default: begin
            end
        endcase
        level_next = encode_level(enable_next, request_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg  <= '0;
            request_reg <= '0;
            level_reg   <= '0;
        end else if (exec) begin
            enable_reg  <= enable_next;
            request_reg <= request_next;
            level_reg   <= level_next;
        end
    end

    assign result.read_data      = rd;
    assign result.mask_pending   = pend;
    assign result.priority_level = level_next;
    assign result.level_changed  = (level_next != level_reg);

endmodule

`default_nettype wire

// File: hw/rtl/sicpc_out_reg.sv
// result register stage
`default_nettype none

module sicpc_out_reg (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               held_valid,
    input  wire sicpc_pkg::result_t result,
    output logic                    advance,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output sicpc_pkg::result_t      out_result
);
    import sicpc_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    assign advance = held_valid && (!valid_reg || out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= advance || (valid_reg && !out_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire

// File: hw/rtl/set_clear_interrupt_priority_controller.sv
// top level of the set/clear interrupt enable and request controller
//
// input channel: s_command with s_value, one transfer per s_valid/s_ready
// handshake. commands write enable or request bits (value bit 15 picks set
// or clear), raise or clear requests, read either register, or test the
// request bits against a mask.
// result channel: one transfer per command on m_valid/m_ready, carrying
// read data, the mask test, the priority level 0 to 6 and a change flag.
// a command taken on the s_valid/s_ready handshake lands in the input
// register and is executed as it moves on to the result register, where
// it is shown on the result channel until m_ready takes it.
// throughput: one command per cycle; the input register and the result
// register each take a new entry in the cycle the next stage frees them.
// when m_ready is low the result holds, the input register still takes one
// more command, and s_ready then drops until the result is taken.
// reset (aresetn low, synchronous) clears enable, request, level and both
// stage valids; no result is pending afterwards.
`default_nettype none

module set_clear_interrupt_priority_controller (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [sicpc_pkg::CMD_W-1:0]    s_command,
    input  wire logic [sicpc_pkg::VALUE_W-1:0]  s_value,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [sicpc_pkg::BITS_W-1:0]        m_read_data,
    output logic                                m_mask_pending,
    output logic [sicpc_pkg::LEVEL_W-1:0]       m_priority_level,
    output logic                                m_level_changed
);
    import sicpc_pkg::*;

    logic               advance;
    logic               held_valid;
    logic [CMD_W-1:0]   held_command;
    logic [VALUE_W-1:0] held_value;
    result_t            result;
    result_t            out_result;

    sicpc_in_reg u_in_reg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .in_command   (s_command),
        .in_value     (s_value),
        .advance      (advance),
        .held_valid   (held_valid),
        .held_command (held_command),
        .held_value   (held_value)
    );

    sicpc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .exec    (advance),
        .command (held_command),
        .value   (held_value),
        .result  (result)
    );

    sicpc_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .held_valid (held_valid),
        .result     (result),
        .advance    (advance),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_result (out_result)
    );

    assign m_read_data      = out_result.read_data;
    assign m_mask_pending   = out_result.mask_pending;
    assign m_priority_level = out_result.priority_level;
    assign m_level_changed  = out_result.level_changed;

endmodule

`default_nettype wire

// File: hw/rtl/sicpc_checker.sv
// port checker for the interrupt controller and its bind
`default_nettype none

module sicpc_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [sicpc_pkg::BITS_W-1:0]  m_read_data,
    input wire logic                          m_mask_pending,
    input wire logic [sicpc_pkg::LEVEL_W-1:0] m_priority_level,
    input wire logic                          m_level_changed
);
    import sicpc_pkg::*;

    // no result pending straight after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data)
            && $stable(m_mask_pending) && $stable(m_priority_level)
            && $stable(m_level_changed))
        else $error("stalled result changed");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_priority_level <= LEVEL_W'(6))
        else $error("priority level out of range");

    // a read never changes the level and never reports a mask hit
    a_read_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_read_data != '0) |-> !m_mask_pending && !m_level_changed)
        else $error("read result with side effects");

    // a query hit comes with no read data and no level change
    a_query_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_mask_pending |-> (m_read_data == '0) && !m_level_changed)
        else $error("query result with side effects");

endmodule

bind set_clear_interrupt_priority_controller sicpc_checker u_sicpc_checker (.*);

`default_nettype wire
